FILE: src/bad_pkg.sv
// Shared types and constants of the block average deadband filter.
package bad_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CHANNEL_W = 1;

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [CHANNEL_W-1:0] t_channel;

    localparam t_sample THRESH_RESET = t_sample'(6);

endpackage

FILE: src/bad_if.sv
// Stream and configuration interfaces of the block average deadband filter.
interface bad_sample_if;
    logic              valid;
    logic              ready;
    bad_pkg::t_channel channel;
    bad_pkg::t_sample  sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface bad_result_if;
    logic             valid;
    logic             ready;
    bad_pkg::t_sample stable_value;

    modport source (output valid, output stable_value, input ready);
    modport sink   (input valid, input stable_value, output ready);
endinterface

interface bad_cfg_if;
    logic             valid;
    logic             ready;
    bad_pkg::t_sample data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/bad_lane.sv
// Per-channel window accumulator with deadband update of the held average.
module bad_lane #(
    parameter int WINDOW_SIZE = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_hit,
    input  bad_pkg::t_sample i_sample,
    input  bad_pkg::t_sample i_threshold,
    output bad_pkg::t_sample o_held
);

    localparam int SUM_W   = bad_pkg::SAMPLE_W + $clog2(WINDOW_SIZE);
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
    // Division by the window is a multiply by a rounded-up reciprocal, which
    // is exact for every sum that fits in SUM_W bits.
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_SIZE);
    localparam int RECIP_W = SUM_W + 2;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW_SIZE);

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    bad_pkg::t_sample  r_held, n_held;

    logic [SUM_W-1:0]  sum_add;
    logic [CNT_W-1:0]  count_add;
    logic              window_done;
    logic [PROD_W-1:0] product;
    bad_pkg::t_sample  average;
    bad_pkg::t_sample  diff;

    always_comb begin
        sum_add     = r_sum + SUM_W'(i_sample);
        count_add   = r_count + CNT_W'(1);
        window_done = (count_add == WINDOW_CNT);
        product     = PROD_W'(sum_add) * PROD_W'(RECIP);
        average     = product[SHIFT +: bad_pkg::SAMPLE_W];
        diff        = (average > r_held) ? (average - r_held) : (r_held - average);

        n_held  = (window_done && (diff >= i_threshold)) ? average : r_held;
        n_sum   = window_done ? '0 : sum_add;
        n_count = window_done ? '0 : count_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_held  <= '0;
        end else if (i_hit) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_held  <= n_held;
        end
    end

    assign o_held = n_held;

endmodule

FILE: src/block_average_deadband_filter.sv
// Block average deadband filter: every accepted sample is added to its channel's
// window; when the window fills, the average replaces the channel's held value
// if it moved by at least the threshold. Each sample returns the held value of
// its channel after that update. One sample is accepted every clock cycle unless
// the input and result registers are both full and the result is not taken. The
// sample lands in the input register at its transfer; the single update stage
// then runs and loads the result register once that register is free or taken.
// A channel number of NUM_CHANNELS or more touches no state and returns zero.
module block_average_deadband_filter #(
    parameter int WINDOW_SIZE  = 8,
    parameter int NUM_CHANNELS = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bad_sample_if.sink   i_sample_if,
    bad_result_if.source o_result_if,
    bad_cfg_if.sink      i_cfg_if
);

    // The one-bit channel field reaches at most two channel stores.
    localparam int NUM_LANES = (NUM_CHANNELS < 2) ? NUM_CHANNELS : 2;

    logic              r_in_valid;
    bad_pkg::t_channel r_in_channel;
    bad_pkg::t_sample  r_in_sample;

    logic              r_out_valid;
    bad_pkg::t_sample  r_out_value, n_out_value;

    bad_pkg::t_sample  r_threshold;

    logic              advance;
    bad_pkg::t_sample  lane_held [NUM_LANES];
    logic [NUM_LANES-1:0] lane_sel;

    assign advance           = !r_out_valid || o_result_if.ready;
    assign i_sample_if.ready = !r_in_valid || advance;
    assign i_cfg_if.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= bad_pkg::THRESH_RESET;
        end else if (i_cfg_if.valid) begin
            r_threshold <= i_cfg_if.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample_if.ready) begin
            r_in_valid <= i_sample_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample_if.ready && i_sample_if.valid) begin
            r_in_channel <= i_sample_if.channel;
            r_in_sample  <= i_sample_if.sample;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_sel[g] = (r_in_channel == bad_pkg::CHANNEL_W'(g));

        bad_lane #(
            .WINDOW_SIZE (WINDOW_SIZE)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_hit       (r_in_valid && advance && lane_sel[g]),
            .i_sample    (r_in_sample),
            .i_threshold (r_threshold),
            .o_held      (lane_held[g])
        );
    end

    always_comb begin
        n_out_value = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            if (lane_sel[k]) begin
                n_out_value = n_out_value | lane_held[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_result_if.valid        = r_out_valid;
    assign o_result_if.stable_value = r_out_value;

endmodule

FILE: bench/bad_checker.sv
// Checker of the block average deadband filter: predicts each stable value and compares results.
`timescale 1ns / 1ps

module bad_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bad_sample_if i_sample_mon,
    bad_result_if i_result_mon,
    bad_cfg_if    i_cfg_mon,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int WINDOW   = 8;
    localparam int NUM_CH   = 2;
    localparam int SHIFT    = $clog2(WINDOW);
    localparam int SUM_W    = bad_pkg::SAMPLE_W + SHIFT;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int MAX_SHOW = 10;

    logic [SUM_W-1:0] win_sum  [NUM_CH];
    logic [CNT_W-1:0] win_cnt  [NUM_CH];
    bad_pkg::t_sample held_avg [NUM_CH];
    bad_pkg::t_sample thresh;
    bad_pkg::t_sample stable_q [$];
    int               fails = 0;

    // Adds one sample to its channel window and gives the held value that follows.
    task automatic fold_sample(input bad_pkg::t_channel ch, input bad_pkg::t_sample smp,
                               output bad_pkg::t_sample held);
        bad_pkg::t_sample avg;
        bad_pkg::t_sample diff;
        if (int'(ch) >= NUM_CH) begin
            held = '0;
        end else begin
            win_sum[ch] = win_sum[ch] + SUM_W'(smp);
            win_cnt[ch] = win_cnt[ch] + CNT_W'(1);
            if (win_cnt[ch] >= CNT_W'(WINDOW)) begin
                avg  = bad_pkg::t_sample'(win_sum[ch] >> SHIFT);
                diff = (avg > held_avg[ch]) ? avg - held_avg[ch] : held_avg[ch] - avg;
                if (diff >= thresh) begin
                    held_avg[ch] = avg;
                end
                win_sum[ch] = '0;
                win_cnt[ch] = '0;
            end
            held = held_avg[ch];
        end
    endtask

    task automatic note_failure(input string what, input bad_pkg::t_sample want,
                                input bad_pkg::t_sample got);
        fails++;
        if (fails <= MAX_SHOW) begin
            $display("%0t: %s: expected stable_value %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        bad_pkg::t_sample held;
        bad_pkg::t_sample want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                win_sum[c]  = '0;
                win_cnt[c]  = '0;
                held_avg[c] = '0;
            end
            thresh = bad_pkg::THRESH_RESET;
            stable_q.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                thresh = i_cfg_mon.data;
            end
            if (i_sample_mon.valid && i_sample_mon.ready) begin
                fold_sample(i_sample_mon.channel, i_sample_mon.sample, held);
                stable_q.push_back(held);
            end
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (stable_q.size() == 0) begin
                    note_failure("result with no sample waiting", '0, i_result_mon.stable_value);
                end else begin
                    want = stable_q.pop_front();
                    if (want !== i_result_mon.stable_value) begin
                        note_failure("mismatch", want, i_result_mon.stable_value);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= stable_q.size();
    end

endmodule

FILE: bench/block_average_deadband_filter_tb.sv
// Top of the block average deadband filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module block_average_deadband_filter_tb;

    localparam int LIMIT      = 200000;
    localparam int LONG_HOLD  = 300;
    localparam int PHASE_ITEMS = 75;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;

    bad_pkg::t_sample level [2];
    int               spread;

    bad_sample_if sample_if ();
    bad_result_if result_if ();
    bad_cfg_if    cfg_if ();

    block_average_deadband_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_if (sample_if),
        .o_result_if (result_if),
        .i_cfg_if    (cfg_if)
    );

    bad_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_mon (sample_if),
        .i_result_mon (result_if),
        .i_cfg_mon    (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("block_average_deadband_filter_tb: FAIL");
            $finish;
        end
    end

    task automatic send_sample(input bad_pkg::t_channel ch, input bad_pkg::t_sample smp);
        int unsigned gap;
        sample_if.valid   <= 1'b1;
        sample_if.channel <= ch;
        sample_if.sample  <= smp;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lowers valid and waits until every sent sample has had its result.
    task automatic drain;
        sample_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_threshold(input bad_pkg::t_sample value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly samples hovering near a level that jumps at random, so that window
    // averages land close to the threshold; now and then a wild reading.
    function automatic bad_pkg::t_sample pick_sample(input bad_pkg::t_channel ch);
        int v;
        int unsigned r;
        r = $urandom_range(0, 15);
        if ($urandom_range(0, 23) == 0) begin
            level[ch] = bad_pkg::t_sample'($urandom_range(0, 4095));
        end
        if (r == 0) begin
            return bad_pkg::t_sample'($urandom_range(0, 4095));
        end else if (r == 1) begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        v = int'(level[ch]) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return bad_pkg::t_sample'(v);
    endfunction

    initial begin : receiver
        int unsigned n;
        bit          held_once;
        held_once = 1'b0;
        result_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !held_once) begin
                held_once = 1'b1;
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 5);
                result_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        bad_pkg::t_sample thresholds [6];
        i_rst_n           <= 1'b0;
        sample_if.valid   <= 1'b0;
        sample_if.channel <= '0;
        sample_if.sample  <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.data       <= '0;
        level[0] = bad_pkg::t_sample'($urandom_range(0, 4095));
        level[1] = bad_pkg::t_sample'($urandom_range(0, 4095));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // At the reset threshold: a full-scale window on channel 0 beside a
        // channel 1 window whose average moves by exactly the threshold.
        for (int i = 0; i < 8; i++) begin
            send_sample(1'b0, '1);
            send_sample(1'b1, bad_pkg::t_sample'(6));
        end
        drain();

        // Zero threshold: a change of one still replaces the held value,
        // and the average truncates 63 / 8 down to 7.
        write_threshold('0);
        for (int i = 0; i < 7; i++) send_sample(1'b1, bad_pkg::t_sample'(7));
        send_sample(1'b1, bad_pkg::t_sample'(14));
        drain();

        thresholds[0] = '1;
        thresholds[1] = '0;
        thresholds[2] = bad_pkg::t_sample'($urandom_range(0, 4095));
        thresholds[3] = bad_pkg::t_sample'(1);
        thresholds[4] = bad_pkg::t_sample'($urandom_range(2, 64));
        thresholds[5] = bad_pkg::THRESH_RESET;

        for (int p = 0; p < 6; p++) begin
            write_threshold(thresholds[p]);
            spread = $urandom_range(0, 96);
            if (p == 2) hold_req = 1'b1;
            if (p == 5) quiet = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                automatic bad_pkg::t_channel ch = bad_pkg::t_channel'($urandom_range(0, 1));
                send_sample(ch, pick_sample(ch));
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("block_average_deadband_filter_tb: PASS");
        end else begin
            $display("block_average_deadband_filter_tb: FAIL");
        end
        $finish;
    end

endmodule
